FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared same-cycle implication and next-cycle property forms
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising clock outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/fem_lma_pkg.sv
// ----------------------------------------------------------------------------
// fem_lma_pkg
// shared types and constants of the lumped mass accumulator
// ----------------------------------------------------------------------------
package fem_lma_pkg;

  localparam int IDX_W    = 12;
  localparam int DATA_W   = 32;
  localparam int MASS_W   = 48;
  localparam int NVERTS   = 8;
  localparam int KIDX_W   = 3;
  localparam int OP_W     = 2;
  localparam int KIND_W   = 2;

  // input packing
  localparam int S_TDATA_W = 2 * DATA_W + NVERTS * IDX_W;
  localparam int S_TUSER_W = OP_W + KIND_W;
  localparam int VERT_LSB  = 2 * DATA_W;
  localparam int M_TDATA_W = 64;

  // divide by three, one byte per step
  localparam int DIGIT_W    = 8;
  localparam int DIV_STEPS  = MASS_W / DIGIT_W;
  localparam int DIV3_MULT  = 683;
  localparam int DIV3_SHIFT = 11;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [KIND_W-1:0] KIND_TRI  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TET  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUAD = 2'd2;
  localparam logic [KIND_W-1:0] KIND_HEX  = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SHARE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_RD_REQ,
    ST_RD_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_start;
    logic clr_wr;
    logic mul;
    logic share_ld;
    logic div_step;
    logic upd_rd;
    logic upd_wr;
    logic rd_req;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0]   in_op;
    logic [KIND_W-1:0] kind;
    logic              div_last;
    logic              k_last;
    logic              clr_last;
    logic              out_free;
  } stat_t;

  // index of the last vertex of an element kind
  function automatic logic [KIDX_W-1:0] last_vert(input logic [KIND_W-1:0] kind);
    logic [KIDX_W-1:0] r;
    unique case (kind)
      KIND_TRI:  r = 3'd2;
      KIND_TET:  r = 3'd3;
      KIND_QUAD: r = 3'd3;
      KIND_HEX:  r = 3'd7;
      default:   r = 3'd7;
    endcase
    return r;
  endfunction

endpackage

FILE: src/fem_lma_ram.sv
// ----------------------------------------------------------------------------
// fem_lma_ram
// single-port ram with registered read data
// ----------------------------------------------------------------------------
module fem_lma_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: src/fem_lma_ctrl.sv
// ----------------------------------------------------------------------------
// fem_lma_ctrl
// sequencer for element updates, vertex reads and store clearing
// ----------------------------------------------------------------------------
module fem_lma_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  fem_lma_pkg::stat_t  stat,
  output fem_lma_pkg::cmd_t   cmd
);

  fem_lma_pkg::state_t state, state_next;
  logic accept;

  assign s_tready = (state == fem_lma_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // reset starts with a clearing pass over the store
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fem_lma_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fem_lma_pkg::ST_CLEAR: begin
        if (stat.clr_last) state_next = fem_lma_pkg::ST_IDLE;
      end
      fem_lma_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (stat.in_op)
            fem_lma_pkg::OP_ADD:   state_next = fem_lma_pkg::ST_MUL;
            fem_lma_pkg::OP_READ:  state_next = fem_lma_pkg::ST_RD_REQ;
            fem_lma_pkg::OP_CLEAR: state_next = fem_lma_pkg::ST_CLEAR;
            default:               state_next = fem_lma_pkg::ST_IDLE;
          endcase
        end
      end
      fem_lma_pkg::ST_MUL: begin
        if (stat.kind == fem_lma_pkg::KIND_TRI) begin
          state_next = fem_lma_pkg::ST_DIV;
        end else begin
          state_next = fem_lma_pkg::ST_SHARE;
        end
      end
      fem_lma_pkg::ST_DIV: begin
        if (stat.div_last) state_next = fem_lma_pkg::ST_UPD_RD;
      end
      fem_lma_pkg::ST_SHARE:  state_next = fem_lma_pkg::ST_UPD_RD;
      fem_lma_pkg::ST_UPD_RD: state_next = fem_lma_pkg::ST_UPD_WR;
      fem_lma_pkg::ST_UPD_WR: begin
        if (stat.k_last) begin
          state_next = fem_lma_pkg::ST_IDLE;
        end else begin
          state_next = fem_lma_pkg::ST_UPD_RD;
        end
      end
      fem_lma_pkg::ST_RD_REQ: state_next = fem_lma_pkg::ST_RD_OUT;
      fem_lma_pkg::ST_RD_OUT: begin
        if (stat.out_free) state_next = fem_lma_pkg::ST_IDLE;
      end
      default: state_next = fem_lma_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      fem_lma_pkg::ST_CLEAR: cmd.clr_wr = 1'b1;
      fem_lma_pkg::ST_IDLE: begin
        cmd.load      = accept;
        cmd.clr_start = accept && (stat.in_op == fem_lma_pkg::OP_CLEAR);
      end
      fem_lma_pkg::ST_MUL:    cmd.mul      = 1'b1;
      fem_lma_pkg::ST_DIV:    cmd.div_step = 1'b1;
      fem_lma_pkg::ST_SHARE:  cmd.share_ld = 1'b1;
      fem_lma_pkg::ST_UPD_RD: cmd.upd_rd   = 1'b1;
      fem_lma_pkg::ST_UPD_WR: cmd.upd_wr   = 1'b1;
      fem_lma_pkg::ST_RD_REQ: cmd.rd_req   = 1'b1;
      fem_lma_pkg::ST_RD_OUT: cmd.out_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: src/fem_lma_dp.sv
// ----------------------------------------------------------------------------
// fem_lma_dp
// element registers, mass product, per-vertex share and mass store
// ----------------------------------------------------------------------------
module fem_lma_dp #(
  parameter int VERTEX_COUNT = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [fem_lma_pkg::S_TDATA_W-1:0]      s_tdata,
  input  logic [fem_lma_pkg::S_TUSER_W-1:0]      s_tuser,
  input  fem_lma_pkg::cmd_t                      cmd,
  output fem_lma_pkg::stat_t                     stat,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [fem_lma_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic                                   m_tuser
);

  localparam int AW = $clog2(VERTEX_COUNT);
  localparam int IW = fem_lma_pkg::IDX_W;
  localparam int MW = fem_lma_pkg::MASS_W;
  localparam int DW = fem_lma_pkg::DATA_W;
  localparam int GW = fem_lma_pkg::DIGIT_W;

  // latched element
  logic [fem_lma_pkg::KIND_W-1:0] kind_q;
  logic [DW-1:0]                  dens_q;
  logic [DW-1:0]                  vol_q;
  logic [IW-1:0]                  verts_q [fem_lma_pkg::NVERTS];

  logic [MW-1:0]                  scaled;
  logic [MW-1:0]                  share;
  logic [1:0]                     rem;
  logic [fem_lma_pkg::KIDX_W-1:0] step;
  logic [fem_lma_pkg::KIDX_W-1:0] k;
  logic [AW-1:0]                  clr_cnt;
  logic                           ovf;

  logic [IW-1:0]                  out_idx;
  logic [MW-1:0]                  out_mass;
  logic                           out_ovf;

  logic [2*DW-1:0]                prod;
  logic [GW+1:0]                  digit_val;
  logic [2*(GW+2)-1:0]            digit_prod;
  logic [GW-1:0]                  digit_q;
  logic [GW+1:0]                  digit_rem;

  logic [31:0]                    vsel_wide, v0_wide;
  logic                           vsel_ok, v0_ok;
  logic [MW:0]                    sum;
  logic [MW-1:0]                  sum_sat;

  logic                           ram_en, ram_we;
  logic [AW-1:0]                  ram_addr;
  logic [MW-1:0]                  ram_wdata, ram_rdata;

  assign prod = dens_q * vol_q;

  // one quotient byte of floor(x/3) per step, remainder carried below 3
  assign digit_val  = {rem, scaled[MW-1 -: GW]};
  assign digit_prod = (2*(GW+2))'(digit_val) * (2*(GW+2))'(fem_lma_pkg::DIV3_MULT);
  assign digit_q    = digit_prod[fem_lma_pkg::DIV3_SHIFT +: GW];
  assign digit_rem  = digit_val - ((GW+2)'({digit_q, 1'b0}) + (GW+2)'(digit_q));

  assign vsel_wide = 32'(verts_q[k]);
  assign v0_wide   = 32'(verts_q[0]);
  assign vsel_ok   = vsel_wide < 32'(VERTEX_COUNT);
  assign v0_ok     = v0_wide < 32'(VERTEX_COUNT);

  assign sum     = {1'b0, ram_rdata} + {1'b0, share};
  assign sum_sat = sum[MW] ? {MW{1'b1}} : sum[MW-1:0];

  // store port
  always_comb begin
    ram_we    = cmd.clr_wr || (cmd.upd_wr && vsel_ok);
    ram_en    = ram_we || (cmd.upd_rd && vsel_ok) || (cmd.rd_req && v0_ok);
    ram_wdata = cmd.clr_wr ? '0 : sum_sat;
    priority if (cmd.clr_wr) begin
      ram_addr = clr_cnt;
    end else if (cmd.rd_req) begin
      ram_addr = v0_wide[AW-1:0];
    end else begin
      ram_addr = vsel_wide[AW-1:0];
    end
  end

  fem_lma_ram #(
    .WIDTH (MW),
    .DEPTH (VERTEX_COUNT)
  ) u_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= s_tuser[fem_lma_pkg::OP_W +: fem_lma_pkg::KIND_W];
      dens_q <= s_tdata[0 +: DW];
      vol_q  <= s_tdata[DW +: DW];
      for (int i = 0; i < fem_lma_pkg::NVERTS; i++) begin
        verts_q[i] <= s_tdata[fem_lma_pkg::VERT_LSB + i*IW +: IW];
      end
    end
    if (cmd.mul) begin
      scaled <= prod[2*DW-1 -: MW];
      rem    <= '0;
    end else if (cmd.div_step) begin
      scaled <= {scaled[MW-GW-1:0], {GW{1'b0}}};
      rem    <= digit_rem[1:0];
    end
    if (cmd.share_ld) begin
      if (kind_q == fem_lma_pkg::KIND_HEX) begin
        share <= {3'b000, scaled[MW-1:3]};
      end else begin
        share <= {2'b00, scaled[MW-1:2]};
      end
    end else if (cmd.div_step) begin
      share <= {share[MW-GW-1:0], digit_q};
    end
    if (cmd.out_load) begin
      out_idx  <= verts_q[0];
      out_mass <= v0_ok ? ram_rdata : '0;
      out_ovf  <= ovf;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= '0;
      k        <= '0;
      clr_cnt  <= '0;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.mul) begin
        step <= '0;
      end else if (cmd.div_step) begin
        step <= step + 1'b1;
      end
      if (cmd.load) begin
        k <= '0;
      end else if (cmd.upd_wr) begin
        k <= k + 1'b1;
      end
      if (cmd.clr_start) begin
        clr_cnt <= '0;
        ovf     <= 1'b0;
      end else if (cmd.clr_wr) begin
        clr_cnt <= clr_cnt + 1'b1;
      end else if (cmd.upd_wr && vsel_ok && sum[MW]) begin
        ovf <= 1'b1;
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign stat.in_op    = s_tuser[0 +: fem_lma_pkg::OP_W];
  assign stat.kind     = kind_q;
  assign stat.div_last = (step == fem_lma_pkg::KIDX_W'(fem_lma_pkg::DIV_STEPS - 1));
  assign stat.k_last   = (k == fem_lma_pkg::last_vert(kind_q));
  assign stat.clr_last = (clr_cnt == AW'(VERTEX_COUNT - 1));
  assign stat.out_free = !m_tvalid || m_tready;

  assign m_tdata = {(fem_lma_pkg::M_TDATA_W - MW - IW)'(0), out_mass, out_idx};
  assign m_tuser = out_ovf;

endmodule

FILE: src/fem_lumped_mass_accumulator.sv
// ----------------------------------------------------------------------------
// fem_lumped_mass_accumulator
// lumped (row-sum) mass assembly over a mesh into a per-vertex mass store
// ----------------------------------------------------------------------------
// The block takes one item at a time. An add item (op 0) forms the element
// mass density*volume (Q16.16 x Q16.16, kept as Q32.16, truncated) and adds
// a share of it to each of the element's vertices: one third for a triangle
// (vert0..2), one quarter for a tetrahedron or quad (vert0..3) and one eighth
// for a hexahedron (vert0..7). Each vertex sum saturates at 2^48-1 and sets a
// sticky overflow flag; a vertex listed twice is updated twice; a vertex at
// or above VERTEX_COUNT is skipped. A read item (op 1) returns vert0, its
// mass (zero when out of range) and the overflow flag as one result item. A
// clear item (op 2) zeroes the store and the flag; op 3 does nothing.
// Every vertex update is a read then a write of the single-port
// mass memory, so the store port sets the rate. An add item is accepted,
// multiplied, then scaled (quarter or eighth) or divided by three a byte
// at a time, then each of its vertices is read and written in turn. A read
// item is accepted, vert0 is read from the store, and the result is loaded
// once the output register is free; new items are accepted while a result
// waits to be taken. A clear item walks the whole store, and after reset a
// clearing pass over the store runs with s_tready low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fem_lumped_mass_accumulator #(
  parameter int VERTEX_COUNT = 4096
) (
  input  logic         clk,
  input  logic         rst,
  // input items
  input  logic         s_tvalid,
  output logic         s_tready,
  // density[31:0], volume[63:32], vert0[75:64] .. vert7[159:148]
  input  logic [159:0] s_tdata,
  // op[1:0], elem_kind[3:2]
  input  logic [3:0]   s_tuser,
  // result items
  output logic         m_tvalid,
  input  logic         m_tready,
  // vertex_index[11:0], vertex_mass[59:12], zero pad [63:60]
  output logic [63:0]  m_tdata,
  // overflowed[0]
  output logic         m_tuser
);

  // commands from the sequencer, status back from the datapath
  fem_lma_pkg::cmd_t  cmd;
  fem_lma_pkg::stat_t stat;

  fem_lma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fem_lma_dp #(
    .VERTEX_COUNT (VERTEX_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // no memory traffic while the block waits for an item
  `ASSERT_IMPL(a_idle_quiet, s_tready, !(cmd.upd_rd || cmd.upd_wr || cmd.clr_wr), "store busy")
  // a result is loaded only into a free output register
  `ASSERT_IMPL(a_no_overwrite, cmd.out_load, !m_tvalid || m_tready, "result overwritten")
  // a new result only ever comes from a read item
  `ASSERT_IMPL(a_out_from_read, $rose(m_tvalid), $past(cmd.out_load), "spurious result")
  // the end of a clearing pass returns to accepting items
  `ASSERT_NEXT(a_clear_ends, cmd.clr_wr && stat.clr_last, s_tready, "clear pass did not end")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the lumped mass accumulator
// ----------------------------------------------------------------------------
// Mesh items go in on the input stream. A shadow copy of the per-vertex mass
// store and the sticky overflow flag is updated as each item is accepted. A
// read item queues the vertex mass expected back, and every result item is
// compared field by field with the oldest queued one. The test tasks run in
// this order:
// - corner elements, repeated vertices, ignored fields and saturation
// - a long hold on the output side while items keep coming in
// - random mesh traffic with idle bursts on both sides
// - a closing stretch with no idling on either side
// ----------------------------------------------------------------------------
module tb_top;

  localparam int VTX_COUNT      = 4096;
  localparam int WATCHDOG_LIMIT = 40000;  // must outlast a clear, which walks the whole store
  localparam int RX_HOLD        = 400;
  localparam int END_WAIT       = VTX_COUNT + 64;

  localparam logic [fem_lma_pkg::OP_W-1:0]   OP_NOP   = 2'd3;  // no effect, no result
  localparam logic [fem_lma_pkg::MASS_W-1:0] MASS_MAX = {fem_lma_pkg::MASS_W{1'b1}};
  localparam logic [fem_lma_pkg::DATA_W-1:0] ONE      = 32'h0001_0000;  // 1.0 in Q16.16

  typedef struct packed {
    logic [fem_lma_pkg::OP_W-1:0]                           op;
    logic [fem_lma_pkg::KIND_W-1:0]                         kind;
    logic [fem_lma_pkg::DATA_W-1:0]                         density;
    logic [fem_lma_pkg::DATA_W-1:0]                         volume;
    logic [fem_lma_pkg::NVERTS-1:0][fem_lma_pkg::IDX_W-1:0] verts;  // verts[0] is vert0
  } mesh_item_t;

  typedef struct packed {
    logic [fem_lma_pkg::IDX_W-1:0]  idx;
    logic [fem_lma_pkg::MASS_W-1:0] mass;
    logic                           ovf;
  } mass_readback_t;

  logic clk = 1'b0;
  logic rst;

  logic         s_tvalid;
  logic         s_tready;
  logic [159:0] s_tdata;   // density[31:0], volume[63:32], vert0[75:64] .. vert7[159:148]
  logic [3:0]   s_tuser;   // op[1:0], elem_kind[3:2]
  logic         m_tvalid;
  logic         m_tready;
  logic [63:0]  m_tdata;   // vertex_index[11:0], vertex_mass[59:12], zero pad [63:60]
  logic         m_tuser;   // overflowed[0]

  // shadow of the block's state
  logic [fem_lma_pkg::MASS_W-1:0] shadow_mass [VTX_COUNT];
  logic                           shadow_ovf;
  mass_readback_t                 pending_readbacks [$];

  int                            mismatch_cnt = 0;
  int                            idle_cycles  = 0;
  int                            rx_hold_cycles = 0;
  bit                            rx_holding = 1'b0;
  bit                            steady_run = 1'b0;
  logic [fem_lma_pkg::IDX_W-1:0] hot_base;

  fem_lumped_mass_accumulator #(
    .VERTEX_COUNT(VTX_COUNT)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // expected behavior
  // ---------------------------------------------------------------------------

  // apply one accepted item to the shadow store; a read queues its result
  task automatic apply_mesh_item(input mesh_item_t it);
    logic [63:0]                    prod;
    logic [fem_lma_pkg::MASS_W-1:0] share;
    logic [fem_lma_pkg::MASS_W:0]   sum;
    logic [3:0]                     div;
    int                             nv;
    mass_readback_t                 rb;
    unique case (it.op)
      fem_lma_pkg::OP_ADD: begin
        unique case (it.kind)
          fem_lma_pkg::KIND_TRI:  begin div = 4'd3; nv = 3; end
          fem_lma_pkg::KIND_TET:  begin div = 4'd4; nv = 4; end
          fem_lma_pkg::KIND_QUAD: begin div = 4'd4; nv = 4; end
          default:                begin div = 4'd8; nv = 8; end
        endcase
        // Q16.16 x Q16.16 is exact Q32.32; drop 16 fraction bits, then share out
        prod  = 64'(it.density) * 64'(it.volume);
        share = fem_lma_pkg::MASS_W'((prod >> 16) / div);
        // a repeated vertex gets the share once per occurrence
        for (int k = 0; k < nv; k++) begin
          if (int'(it.verts[k]) < VTX_COUNT) begin
            sum = {1'b0, shadow_mass[it.verts[k]]} + {1'b0, share};
            if (sum[fem_lma_pkg::MASS_W]) begin
              shadow_mass[it.verts[k]] = MASS_MAX;
              shadow_ovf = 1'b1;
            end else begin
              shadow_mass[it.verts[k]] = sum[fem_lma_pkg::MASS_W-1:0];
            end
          end
        end
      end
      fem_lma_pkg::OP_READ: begin
        rb.idx  = it.verts[0];
        rb.mass = (int'(it.verts[0]) < VTX_COUNT) ? shadow_mass[it.verts[0]] : '0;
        rb.ovf  = shadow_ovf;
        pending_readbacks.push_back(rb);
      end
      fem_lma_pkg::OP_CLEAR: begin
        foreach (shadow_mass[i]) shadow_mass[i] = '0;
        shadow_ovf = 1'b0;
      end
      default: ;  // unknown op leaves everything alone
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offer one item and hold it until the block takes it; tvalid stays high
  task automatic send_item(input mesh_item_t it);
    s_tdata  <= {it.verts, it.volume, it.density};
    s_tuser  <= {it.kind, it.op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    apply_mesh_item(it);
  endtask

  task automatic sender_gap(input int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // at least one idle cycle, then until every pending read has come back
  task automatic pause_until_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_readbacks.size() != 0);
  endtask

  // every field random, including the ones an op ignores
  function automatic mesh_item_t junk_item();
    mesh_item_t it;
    it.op      = fem_lma_pkg::OP_W'($urandom);
    it.kind    = fem_lma_pkg::KIND_W'($urandom);
    it.density = $urandom;
    it.volume  = $urandom;
    for (int k = 0; k < fem_lma_pkg::NVERTS; k++) it.verts[k] = fem_lma_pkg::IDX_W'($urandom);
    return it;
  endfunction

  function automatic mesh_item_t elem(
    input logic [fem_lma_pkg::OP_W-1:0]                           op,
    input logic [fem_lma_pkg::KIND_W-1:0]                         kind,
    input logic [fem_lma_pkg::DATA_W-1:0]                         density,
    input logic [fem_lma_pkg::DATA_W-1:0]                         volume,
    input logic [fem_lma_pkg::NVERTS-1:0][fem_lma_pkg::IDX_W-1:0] verts
  );
    mesh_item_t it;
    it.op      = op;
    it.kind    = kind;
    it.density = density;
    it.volume  = volume;
    it.verts   = verts;
    return it;
  endfunction

  task automatic read_vertex(input logic [fem_lma_pkg::IDX_W-1:0] v);
    mesh_item_t it;
    it          = junk_item();
    it.op       = fem_lma_pkg::OP_READ;
    it.verts[0] = v;
    send_item(it);
  endtask

  // mostly adds and reads around a small cluster of vertices, so that sums
  // build up and saturate now and then; rare clears reset the flag
  function automatic mesh_item_t random_mesh_item();
    mesh_item_t it;
    int         r;
    it = junk_item();
    r  = $urandom_range(0, 99);
    if (r < 55)      it.op = fem_lma_pkg::OP_ADD;
    else if (r < 90) it.op = fem_lma_pkg::OP_READ;
    else if (r < 93) it.op = fem_lma_pkg::OP_CLEAR;
    else             it.op = OP_NOP;
    if ($urandom_range(0, 4) != 0)
      for (int k = 0; k < fem_lma_pkg::NVERTS; k++)
        it.verts[k] = hot_base + fem_lma_pkg::IDX_W'($urandom_range(0, 15));
    if ($urandom_range(0, 9) == 0)
      for (int k = 1; k < fem_lma_pkg::NVERTS; k++) it.verts[k] = it.verts[0];
    r = $urandom_range(0, 9);
    if (r < 7) begin
      it.density = $urandom_range(0, 32'h0040_0000);
      it.volume  = $urandom_range(0, 32'h0040_0000);
    end else if (r == 9) begin
      it.density = 32'hFFFF_0000 | $urandom_range(0, 16'hFFFF);
      it.volume  = 32'hFFFF_0000 | $urandom_range(0, 16'hFFFF);
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // output side: random ready bursts, a long hold on request, steady at the end
  // ---------------------------------------------------------------------------
  initial begin : rx_side
    int n;
    forever begin
      if (rx_hold_cycles > 0) begin
        m_tready   <= 1'b0;
        rx_holding = 1'b1;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
        rx_holding     = 1'b0;
      end else if (steady_run) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          m_tready <= 1'b0;
          n = $urandom_range(1, 18);
        end else begin
          m_tready <= 1'b1;
          n = $urandom_range(1, 40);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  // compare each result item with the oldest pending read
  always @(posedge clk) begin : check_results
    mass_readback_t want;
    if (rst !== 1'b1 && m_tvalid && m_tready) begin
      if (pending_readbacks.size() == 0) begin
        $error("result with no pending read: vertex_index %0d",
               m_tdata[fem_lma_pkg::IDX_W-1:0]);
        mismatch_cnt++;
      end else begin
        want = pending_readbacks.pop_front();
        if (m_tdata[fem_lma_pkg::IDX_W-1:0] !== want.idx) begin
          $error("vertex_index mismatch: expected %0d, got %0d",
                 want.idx, m_tdata[fem_lma_pkg::IDX_W-1:0]);
          mismatch_cnt++;
        end
        if (m_tdata[fem_lma_pkg::IDX_W +: fem_lma_pkg::MASS_W] !== want.mass) begin
          $error("vertex_mass mismatch: expected 0x%012h, got 0x%012h",
                 want.mass, m_tdata[fem_lma_pkg::IDX_W +: fem_lma_pkg::MASS_W]);
          mismatch_cnt++;
        end
        if (m_tuser !== want.ovf) begin
          $error("overflowed mismatch: expected %0b, got %0b", want.ovf, m_tuser);
          mismatch_cnt++;
        end
      end
    end
  end

  // no item moved on either side for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("** fem_lumped_mass_accumulator: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // vertex lists below are written vert7 first, vert0 last
  task automatic test_directed_corners();
    // fresh store reads zero at both ends of the index range
    read_vertex(12'd0);
    read_vertex(12'd4095);
    // triangle of mass 3.0: 1.0 to vert0..2, junk in vert3..7 is ignored
    send_item(elem(fem_lma_pkg::OP_ADD, fem_lma_pkg::KIND_TRI, ONE, 3 * ONE,
                   {{5{12'd9}}, 12'd2, 12'd1, 12'd0}));
    // tetrahedron with top density, vert4..7 junk
    send_item(elem(fem_lma_pkg::OP_ADD, fem_lma_pkg::KIND_TET, 32'hFFFF_FFFF, ONE,
                   {{4{12'd1}}, 12'd4095, 12'd4094, 12'd0, 12'd1}));
    // quad naming one vertex four times
    send_item(elem(fem_lma_pkg::OP_ADD, fem_lma_pkg::KIND_QUAD, 32'h0002_8000,
                   32'h0001_8000, {8{12'd5}}));
    // hexahedron of zero mass
    send_item(elem(fem_lma_pkg::OP_ADD, fem_lma_pkg::KIND_HEX, 32'h0, 32'hFFFF_FFFF,
                   {12'd15, 12'd14, 12'd13, 12'd12, 12'd11, 12'd10, 12'd9, 12'd8}));
    // hexahedron with a fraction that truncates
    send_item(elem(fem_lma_pkg::OP_ADD, fem_lma_pkg::KIND_HEX, 32'h0007_4000, 32'h0000_1999,
                   {12'd23, 12'd22, 12'd21, 12'd20, 12'd19, 12'd18, 12'd17, 12'd16}));
    // smallest nonzero product truncates to a zero share
    send_item(elem(fem_lma_pkg::OP_ADD, fem_lma_pkg::KIND_TRI, 32'h1, 32'h1, {8{12'd0}}));
    // unknown op with every field set
    send_item(elem(OP_NOP, fem_lma_pkg::KIND_HEX, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   {8{12'hFFF}}));
    read_vertex(12'd0);
    read_vertex(12'd1);
    read_vertex(12'd2);
    read_vertex(12'd5);
    read_vertex(12'd4095);
    read_vertex(12'd9);
    read_vertex(12'd16);
    // two full triangles on one vertex saturate it and set the sticky flag
    send_item(elem(fem_lma_pkg::OP_ADD, fem_lma_pkg::KIND_TRI, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   {8{12'd100}}));
    send_item(elem(fem_lma_pkg::OP_ADD, fem_lma_pkg::KIND_TRI, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   {8{12'd100}}));
    // a full hexahedron on one vertex ends just short of saturation
    send_item(elem(fem_lma_pkg::OP_ADD, fem_lma_pkg::KIND_HEX, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   {8{12'd200}}));
    read_vertex(12'd100);
    read_vertex(12'd200);
    // clear wipes the store and the flag
    send_item(elem(fem_lma_pkg::OP_CLEAR, fem_lma_pkg::KIND_TRI, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, {8{12'd100}}));
    read_vertex(12'd100);
    read_vertex(12'd200);
    pause_until_drained();
  endtask

  // output held off while reads and adds keep arriving: the result register
  // fills and the input has to stall
  task automatic test_output_backpressure();
    mesh_item_t it;
    rx_hold_cycles = RX_HOLD;
    while (!rx_holding) @(posedge clk);
    for (int i = 0; i < 16; i++) begin
      it    = random_mesh_item();
      it.op = (i % 2 == 0) ? fem_lma_pkg::OP_READ : fem_lma_pkg::OP_ADD;
      send_item(it);
    end
    pause_until_drained();
  endtask

  task automatic test_random_mesh(input int n_items);
    mesh_item_t it;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 18));
      if (i % 250 == 249) pause_until_drained();
      it = random_mesh_item();
      send_item(it);
      // after a clear, build up a fresh cluster somewhere else
      if (it.op == fem_lma_pkg::OP_CLEAR) hot_base = fem_lma_pkg::IDX_W'($urandom);
    end
  endtask

  task automatic test_steady_stream(input int n_items);
    steady_run = 1'b1;
    for (int i = 0; i < n_items; i++) send_item(random_mesh_item());
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    foreach (shadow_mass[i]) shadow_mass[i] = '0;
    shadow_ovf = 1'b0;
    hot_base   = fem_lma_pkg::IDX_W'($urandom);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_directed_corners();
    test_output_backpressure();
    test_random_mesh(1150);
    test_steady_stream(200);

    // let the last results out, then watch for anything spurious
    pause_until_drained();
    repeat (END_WAIT) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("** fem_lumped_mass_accumulator: PASSED **");
    end else begin
      $display("** fem_lumped_mass_accumulator: FAILED **");
    end
    $finish;
  end

endmodule
